// ===== hdl/uat_pkg.sv =====
// Shared types and codes for the unordered array table.
`default_nettype none

package uat_pkg;

   localparam logic [1:0] OP_SEARCH = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] RSP_OK        = 2'd0;
   localparam logic [1:0] RSP_NOT_FOUND = 2'd1;
   localparam logic [1:0] RSP_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [4:0] position;
      logic [5:0] fill_count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_DECODE,
      CTL_SCAN_RD,
      CTL_SCAN_CMP,
      CTL_SHIFT_RD,
      CTL_SHIFT_WR,
      CTL_REPLY
   } ctl_state_type;

   typedef struct packed {
      logic       load_req;
      logic       idx_clr;
      logic       idx_inc;
      logic       rd_en;
      logic       rd_next;
      logic       wr_insert;
      logic       wr_shift;
      logic       inc_count;
      logic       dec_count;
      logic       set_result;
      logic [1:0] res_status;
      logic       pos_from_count;
      logic       rsp_load;
   } uat_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       at_end;
      logic       last;
      logic       match;
      logic       rsp_free;
   } uat_stat_type;

endpackage

`default_nettype wire

// ===== hdl/unordered_array_table.sv =====
// Unordered array table: one transaction at a time through a single-port table memory.
// Insert or an unused selector goes from decode straight to reply; search compares
// each entry until a hit or the end of the filled entries; delete scans likewise and
// on a hit shifts later entries down one place. One transaction is in flight; the next
// is taken while the result waits; a held result stalls the block in its reply state.
// Reset: synchronous, empties the table (count zero); entries are not cleared.
`default_nettype none

module unordered_array_table
   import uat_pkg::*;
#(
   parameter int DEPTH = 32
)(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output rsp_payload_type      rsp_payload
);

   uat_cmd_type  cmd;
   uat_stat_type stat;

   uat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   uat_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

`default_nettype wire

// ===== hdl/uat_ctrl.sv =====
// Sequencer for search, insert and delete over the table memory.
`default_nettype none

module uat_ctrl
   import uat_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire uat_stat_type stat,
   output uat_cmd_type       cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_valid) state_in = CTL_DECODE;
         end
         CTL_DECODE: begin
            if (stat.op == OP_SEARCH || stat.op == OP_DELETE) state_in = CTL_SCAN_RD;
            else state_in = CTL_REPLY;
         end
         CTL_SCAN_RD: begin
            if (stat.at_end) state_in = CTL_REPLY;
            else state_in = CTL_SCAN_CMP;
         end
         CTL_SCAN_CMP: begin
            if (!stat.match) state_in = CTL_SCAN_RD;
            else if (stat.op == OP_DELETE) state_in = CTL_SHIFT_RD;
            else state_in = CTL_REPLY;
         end
         CTL_SHIFT_RD: begin
            if (stat.last) state_in = CTL_REPLY;
            else state_in = CTL_SHIFT_WR;
         end
         CTL_SHIFT_WR: begin
            state_in = CTL_SHIFT_RD;
         end
         CTL_REPLY: begin
            if (stat.rsp_free) state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         CTL_DECODE: begin
            cmd.idx_clr = 1'b1;
            if (stat.op == OP_INSERT) begin
               cmd.set_result = 1'b1;
               if (stat.full) begin
                  cmd.res_status = RSP_FULL;
               end else begin
                  cmd.res_status     = RSP_OK;
                  cmd.pos_from_count = 1'b1;
                  cmd.wr_insert      = 1'b1;
                  cmd.inc_count      = 1'b1;
               end
            end else if (stat.op != OP_SEARCH && stat.op != OP_DELETE) begin
               cmd.set_result = 1'b1;
               cmd.res_status = RSP_NOT_FOUND;
            end
         end
         CTL_SCAN_RD: begin
            if (stat.at_end) begin
               cmd.set_result = 1'b1;
               cmd.res_status = RSP_NOT_FOUND;
            end else begin
               cmd.rd_en = 1'b1;
            end
         end
         CTL_SCAN_CMP: begin
            if (stat.match) begin
               cmd.set_result = 1'b1;
               cmd.res_status = RSP_OK;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         CTL_SHIFT_RD: begin
            if (stat.last) begin
               cmd.dec_count = 1'b1;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
            end
         end
         CTL_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         CTL_REPLY: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/uat_datapath.sv =====
// Table memory, fill count, scan index and response register.
`default_nettype none

module uat_datapath
   import uat_pkg::*;
#(
   parameter int DEPTH = 32
)(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_payload_type req_payload,
   input  wire logic            rsp_ready,
   output logic                 rsp_valid,
   output rsp_payload_type      rsp_payload,
   input  wire uat_cmd_type     cmd,
   output uat_stat_type         stat
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 5) ? CW : 5;
   localparam int FW = (CW > 6) ? CW : 6;

   logic [31:0]     mem [DEPTH];
   logic [31:0]     rdata_ff;
   req_payload_type req_ff;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [1:0]      res_status_ff;
   logic [CW-1:0]   res_pos_ff;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0]   rd_addr;
   logic [IW-1:0]   wr_addr;
   logic [31:0]     wr_data;
   logic            wr_en;
   logic [CW:0]     idx_next;
   logic [PW-1:0]   pos_ext;
   logic [FW-1:0]   count_ext;

   assign idx_next = {1'b0, idx_ff} + (CW + 1)'(1);
   assign rd_addr  = cmd.rd_next ? idx_next[IW-1:0] : idx_ff[IW-1:0];
   assign wr_en    = cmd.wr_insert | cmd.wr_shift;
   assign wr_addr  = cmd.wr_insert ? count_ff[IW-1:0] : idx_ff[IW-1:0];
   assign wr_data  = cmd.wr_insert ? req_ff.value : rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) req_ff <= req_payload;
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) idx_in = '0;
      else if (cmd.idx_inc) idx_in = idx_next[CW-1:0];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.inc_count) count_in = count_ff + CW'(1);
      else if (cmd.dec_count) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.set_result) begin
         res_status_ff <= cmd.res_status;
         if (cmd.res_status != RSP_OK) res_pos_ff <= '0;
         else if (cmd.pos_from_count) res_pos_ff <= count_ff;
         else res_pos_ff <= idx_ff;
      end
   end

   assign pos_ext   = PW'(res_pos_ff);
   assign count_ext = FW'(count_ff);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status     <= res_status_ff;
         rsp_ff.position   <= pos_ext[4:0];
         rsp_ff.fill_count <= count_ext[5:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign stat.op       = req_ff.req_type;
   assign stat.full     = (count_ff >= CW'(DEPTH));
   assign stat.at_end   = (idx_ff >= count_ff);
   assign stat.last     = (idx_next >= {1'b0, count_ff});
   assign stat.match    = (rdata_ff == req_ff.value);
   assign stat.rsp_free = ~rsp_valid_ff | rsp_ready;

endmodule

`default_nettype wire

// ===== hdl/uat_checker.sv =====
// Port-level checks for the unordered array table, bound to the top level.
`default_nettype none

module uat_checker
   import uat_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_ready,
   input wire req_payload_type req_payload,
   input wire logic            rsp_valid,
   input wire logic            rsp_ready,
   input wire rsp_payload_type rsp_payload
);

   logic [33:0] req_seen;
   assign req_seen = {req_valid, req_ready, req_payload.value};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transaction");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == RSP_OK || rsp_payload.status == RSP_NOT_FOUND
                     || rsp_payload.status == RSP_FULL))
      else $error("bad status code");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != RSP_OK |-> rsp_payload.position == 5'd0)
      else $error("position set on failed request");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_seen[32])
      else $error("not idle after reset");

endmodule

bind unordered_array_table uat_checker u_checker (.*);

`default_nettype wire
